// ===== src/mabt_pkg.sv =====
// ----------------------------------------------------------------------------
// mabt_pkg
// Shared constants and types for the majority-ack broadcast tracker.
// ----------------------------------------------------------------------------
package mabt_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned MSG_SLOTS_DEF = 256;

  localparam int unsigned OP_W    = 1;
  localparam int unsigned PID_W   = 4;
  localparam int unsigned MSG_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned NPROC_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_LOCAL = 1'b0,
    OP_RECV  = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FWD = 2'd0,
    KIND_DLV = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_PROCS = 1'b0,
    REG_LOCAL_ID  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic  capture;
    logic  scan;
    logic  take_hit;
    logic  take_new;
    logic  modify;
    logic  commit;
    kind_e emit_kind;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
    logic fwd;
    logic deliver;
    logic deliver_pend;
  } sts_t;

endpackage

// ===== src/mabt_req_if.sv =====
// ----------------------------------------------------------------------------
// mabt_req_if
// Request channel: op, origin, message id and sender of one request.
// ----------------------------------------------------------------------------
interface mabt_req_if import mabt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [PID_W-1:0]   origin_id;
  logic [MSG_W-1:0]   msg_id;
  logic [PID_W-1:0]   sender_id;

  modport source (output valid, output op, output origin_id, output msg_id,
                  output sender_id, input ready);
  modport sink   (input valid, input op, input origin_id, input msg_id,
                  input sender_id, output ready);
endinterface

// ===== src/mabt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mabt_rsp_if
// Result channel: forward, deliver or table-full results.
// ----------------------------------------------------------------------------
interface mabt_rsp_if import mabt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PID_W-1:0]   out_origin;
  logic [MSG_W-1:0]   out_msg;
  logic [PID_W-1:0]   out_sender;
  logic               last;

  modport source (output valid, output kind, output out_origin, output out_msg,
                  output out_sender, output last, input ready);
  modport sink   (input valid, input kind, input out_origin, input out_msg,
                  input out_sender, input last, output ready);
endinterface

// ===== src/mabt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mabt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mabt_cfg_if import mabt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/mabt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mabt_ctrl
// Sequencer: table scan, read-modify-write, majority check, result issue.
// ----------------------------------------------------------------------------
module mabt_ctrl import mabt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_MODIFY = 7'b0000100,
    S_COMMIT = 7'b0001000,
    S_FWD    = 7'b0010000,
    S_DLV    = 7'b0100000,
    S_ERR    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.emit_kind = KIND_FWD;
    req_ready_o     = 1'b0;
    rsp_valid_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = S_MODIFY;
        end else if (sts_i.scan_done) begin
          if (sts_i.full) begin
            state_d = S_ERR;
          end else begin
            cmd_o.take_new = 1'b1;
            state_d        = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.fwd) begin
          state_d = S_FWD;
        end else if (sts_i.deliver) begin
          state_d = S_DLV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FWD: begin
        rsp_valid_o     = 1'b1;
        cmd_o.emit_kind = KIND_FWD;
        if (rsp_ready_i) begin
          state_d = sts_i.deliver_pend ? S_DLV : S_IDLE;
        end
      end
      S_DLV: begin
        rsp_valid_o     = 1'b1;
        cmd_o.emit_kind = KIND_DLV;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        rsp_valid_o     = 1'b1;
        cmd_o.emit_kind = KIND_ERR;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/mabt_dp.sv =====
// ----------------------------------------------------------------------------
// mabt_dp
// Datapath: configuration, message table memory, ack mask update, popcount.
// ----------------------------------------------------------------------------
module mabt_dp import mabt_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned MSG_SLOTS = MSG_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [PID_W-1:0]      origin_id_i,
  input  logic [MSG_W-1:0]      msg_id_i,
  input  logic [PID_W-1:0]      sender_id_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [PID_W-1:0]      out_origin_o,
  output logic [MSG_W-1:0]      out_msg_o,
  output logic [PID_W-1:0]      out_sender_o,
  output logic                  last_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned AW    = $clog2(MSG_SLOTS);
  localparam int unsigned CW    = $clog2(MSG_SLOTS + 1);
  localparam int unsigned CNTW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned CMPW  = (CNTW > NPROC_W) ? CNTW : NPROC_W;
  localparam int unsigned KEY_W = PID_W + MSG_W;
  localparam int unsigned EW    = KEY_W + MAX_PROCS + 1;

  logic [NPROC_W-1:0]   num_procs_q;
  logic [PID_W-1:0]     local_id_q;

  logic [OP_W-1:0]      op_q;
  logic [PID_W-1:0]     org_q;
  logic [MSG_W-1:0]     msg_q;
  logic [PID_W-1:0]     snd_q;

  logic [CW-1:0]        fill_q;
  logic [CW-1:0]        scan_q;
  logic                 rdv_q;
  logic [AW-1:0]        rdidx_q;
  logic [EW-1:0]        rd_q;
  logic [EW-1:0]        mem_q [MSG_SLOTS];

  logic [AW-1:0]        slot_q;
  logic [MAX_PROCS-1:0] mask_q;
  logic                 dlv_q;
  logic                 new_q;
  logic                 fwd_q;
  logic                 deliver_q;

  logic                 issue;
  logic                 hit;
  logic                 fwd_now;
  logic [MAX_PROCS-1:0] snd_bit;
  logic [MAX_PROCS-1:0] loc_bit;
  logic [CNTW-1:0]      ack_cnt;
  logic                 deliver;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_procs_q <= NPROC_W'(1);
      local_id_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NUM_PROCS: num_procs_q <= cfg_data_i[NPROC_W-1:0];
        REG_LOCAL_ID:  local_id_q  <= cfg_data_i[PID_W-1:0];
        default: ;
      endcase
    end
  end

  assign issue = cmd_i.scan && (scan_q < fill_q) && !hit;
  assign hit   = rdv_q && (rd_q[EW-1 -: KEY_W] == {org_q, msg_q});

  assign snd_bit = MAX_PROCS'(1) << snd_q;
  assign loc_bit = MAX_PROCS'(1) << local_id_q;
  assign fwd_now = (op_q == OP_LOCAL) || new_q;

  always_comb begin
    ack_cnt = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      ack_cnt = ack_cnt + CNTW'(mask_q[i]);
    end
  end

  assign deliver = !dlv_q && (CMPW'(ack_cnt) > CMPW'(num_procs_q >> 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      org_q <= origin_id_i;
      msg_q <= msg_id_i;
      snd_q <= sender_id_i;
    end
    if (issue) begin
      rd_q    <= mem_q[scan_q[AW-1:0]];
      rdidx_q <= scan_q[AW-1:0];
    end
    if (cmd_i.take_hit) begin
      slot_q <= rdidx_q;
      mask_q <= rd_q[MAX_PROCS:1];
      dlv_q  <= rd_q[0];
      new_q  <= 1'b0;
    end else if (cmd_i.take_new) begin
      slot_q <= fill_q[AW-1:0];
      mask_q <= '0;
      dlv_q  <= 1'b0;
      new_q  <= 1'b1;
    end else if (cmd_i.modify) begin
      mask_q <= mask_q | snd_bit | (fwd_now ? loc_bit : '0);
      fwd_q  <= fwd_now;
    end
    if (cmd_i.commit) begin
      mem_q[slot_q] <= {org_q, msg_q, mask_q, dlv_q | deliver};
      deliver_q     <= deliver;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      scan_q <= '0;
      rdv_q  <= 1'b0;
    end else begin
      rdv_q <= issue;
      if (cmd_i.capture) begin
        scan_q <= '0;
      end else if (issue) begin
        scan_q <= scan_q + CW'(1);
      end
      if (cmd_i.commit && new_q) begin
        fill_q <= fill_q + CW'(1);
      end
    end
  end

  assign sts_o.hit          = hit;
  assign sts_o.scan_done    = (scan_q == fill_q) && !rdv_q;
  assign sts_o.full         = (fill_q == CW'(MSG_SLOTS));
  assign sts_o.fwd          = fwd_q;
  assign sts_o.deliver      = deliver;
  assign sts_o.deliver_pend = deliver_q;

  assign kind_o       = cmd_i.emit_kind;
  assign out_origin_o = org_q;
  assign out_msg_o    = msg_q;
  assign out_sender_o = (cmd_i.emit_kind == KIND_FWD) ? local_id_q : '0;
  assign last_o       = (cmd_i.emit_kind == KIND_FWD) ? !deliver_q : 1'b1;

endmodule

// ===== src/majority_ack_broadcast_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// majority_ack_broadcast_tracker_unit
// Majority-ack broadcast tracker: message table with ack masks, forward and
// deliver and table-full results.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cfg_i    in   valid/ready    index, data (0 num_processes, 1 local_id)
//  req_i    in   valid/ready    op, origin_id, msg_id, sender_id
//  rsp_o    out  valid/ready    kind, out_origin, out_msg, out_sender, last
//
//  One request at a time: accepted in the idle cycle, then a table scan at
//  one entry per cycle through the single memory port up to a hit or, on a
//  miss, the fill count (then a full table gives a table-full result), then
//  update and majority count in states MODIFY and COMMIT, then one cycle per
//  result while rsp_o is ready. No clearing pass after reset: a fill count
//  tracks the used slots. rsp_o stalls hold the unit; cfg_i is always ready.
// ----------------------------------------------------------------------------
module majority_ack_broadcast_tracker_unit import mabt_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned MSG_SLOTS = MSG_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mabt_cfg_if.sink   cfg_i,
  mabt_req_if.sink   req_i,
  mabt_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  mabt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mabt_dp #(
    .MAX_PROCS (MAX_PROCS),
    .MSG_SLOTS (MSG_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .op_i         (req_i.op),
    .origin_id_i  (req_i.origin_id),
    .msg_id_i     (req_i.msg_id),
    .sender_id_i  (req_i.sender_id),
    .kind_o       (rsp_o.kind),
    .out_origin_o (rsp_o.out_origin),
    .out_msg_o    (rsp_o.out_msg),
    .out_sender_o (rsp_o.out_sender),
    .last_o       (rsp_o.last),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== dv/majority_ack_broadcast_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// majority_ack_broadcast_tracker_unit_tb
// Self-checking bench for the majority-ack broadcast tracker. A short table of
// directed requests and register writes runs first. Some rows carry their
// results typed in, and the rest are checked against a behavioral copy of the
// message table. Random request streams follow under eight register settings:
// message lifecycles (new key, then copies from random senders), key reuse,
// stray requests and table overflow. Both sides idle at random, with one quiet
// phase and one long result hold-off. Every result is compared field by field
// in order.
// ----------------------------------------------------------------------------
module majority_ack_broadcast_tracker_unit_tb;
  import mabt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = MSG_SLOTS_DEF + 48;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int          PHASE_ITEMS  = 230;
  localparam int          PHASES       = 8;
  localparam int          DIR_N        = 24;

  typedef struct packed {
    kind_e            kind;
    logic [PID_W-1:0] origin;
    logic [MSG_W-1:0] msg;
    logic [PID_W-1:0] sender;
    logic             last;
  } bcast_rsp_t;

  typedef struct packed {
    logic [PID_W-1:0] origin;
    logic [MSG_W-1:0] msg;
  } msg_key_t;

  typedef struct {
    bit                    cfg_write;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    op_e                   op;
    logic [PID_W-1:0]      origin;
    logic [MSG_W-1:0]      msg;
    logic [PID_W-1:0]      sender;
    int                    n_fixed;
    kind_e                 k0;
    kind_e                 k1;
    logic [PID_W-1:0]      fwd_sender;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mabt_cfg_if cfg_bus ();
  mabt_req_if req_bus ();
  mabt_rsp_if rsp_bus ();

  majority_ack_broadcast_tracker_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bit               entry_live [MSG_SLOTS_DEF];
  logic [PID_W-1:0] entry_origin [MSG_SLOTS_DEF];
  logic [MSG_W-1:0] entry_msg [MSG_SLOTS_DEF];
  logic [15:0]      entry_acks [MSG_SLOTS_DEF];
  bit               entry_fwd [MSG_SLOTS_DEF];
  bit               entry_dlv [MSG_SLOTS_DEF];
  logic [NPROC_W-1:0] group_size = 5'd1;
  logic [PID_W-1:0]   self_id    = 4'd0;

  bcast_rsp_t  pending_results [$];
  msg_key_t    known_keys [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          rsp_hold_ask = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_LOCAL, 4'd0, 32'h0, 4'd0, 2, KIND_FWD, KIND_DLV, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd15, 32'hFFFF_FFFF, 4'd15, 2, KIND_FWD, KIND_DLV,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd0, 32'h0, 4'd5, 0, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_LOCAL, 4'd0, 32'h0, 4'd3, 1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b1, REG_NUM_PROCS, 5'd16, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b1, REG_LOCAL_ID, 5'd15, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd2, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd4, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd5, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd6, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd7, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd8, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd9, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd10, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd3, 32'h8000_0001, 4'd2, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_LOCAL, 4'd3, 32'h8000_0001, 4'd1, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b1, REG_NUM_PROCS, 5'd3, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd7, 32'h0000_1234, 4'd15, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_LOCAL, 4'd7, 32'h0000_1234, 4'd0, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b1, REG_NUM_PROCS, 5'd0, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd1, 32'h5A5A_5A5A, 4'd0, -1, KIND_FWD, KIND_FWD,
      4'd0},
    '{1'b1, REG_NUM_PROCS, 5'd31, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b1, REG_LOCAL_ID, 5'd0, OP_LOCAL, 4'd0, 32'h0, 4'd0, -1, KIND_FWD, KIND_FWD, 4'd0},
    '{1'b0, REG_NUM_PROCS, 5'd0, OP_RECV, 4'd9, 32'h7FFF_FFFF, 4'd1, -1, KIND_FWD, KIND_FWD,
      4'd0}
  };

  logic [NPROC_W-1:0] phase_np  [PHASES] = '{5'd5, 5'd16, 5'd1, 5'd0, 5'd17, 5'd31, 5'd3,
                                             5'd16};
  logic [PID_W-1:0]   phase_lid [PHASES] = '{4'd2, 4'd15, 4'd0, 4'd7, 4'd9, 4'd4, 4'd11,
                                             4'd15};

  function automatic void expect_result(bcast_rsp_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic void remember_key(msg_key_t key);
    known_keys.insert(known_keys.size(), key);
  endfunction

  function automatic void track_request(op_e op, logic [PID_W-1:0] org,
                                        logic [MSG_W-1:0] msg, logic [PID_W-1:0] snd,
                                        bit use_model);
    int         slot = -1;
    int         spare = -1;
    bit         fwd = 1'b0;
    bit         dlv;
    bcast_rsp_t res;
    msg_key_t   new_key;
    for (int i = 0; i < MSG_SLOTS_DEF; i++) begin
      if (entry_live[i]) begin
        if (slot < 0 && entry_origin[i] == org && entry_msg[i] == msg) slot = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (slot < 0) begin
      if (spare < 0) begin
        if (use_model) begin
          res = '{KIND_ERR, org, msg, 4'd0, 1'b1};
          expect_result(res);
        end
        return;
      end
      slot = spare;
      entry_live[slot]   = 1'b1;
      entry_origin[slot] = org;
      entry_msg[slot]    = msg;
      entry_acks[slot]   = '0;
      entry_fwd[slot]    = 1'b0;
      entry_dlv[slot]    = 1'b0;
      new_key.origin     = org;
      new_key.msg        = msg;
      remember_key(new_key);
    end
    entry_acks[slot] |= 16'd1 << snd;
    if (op == OP_LOCAL || !entry_fwd[slot]) begin
      entry_fwd[slot] = 1'b1;
      entry_acks[slot] |= 16'd1 << self_id;
      fwd = 1'b1;
    end
    dlv = entry_fwd[slot] && !entry_dlv[slot] &&
          ($countones(entry_acks[slot]) > int'(group_size / 2));
    if (dlv) entry_dlv[slot] = 1'b1;
    if (use_model) begin
      if (fwd) begin
        res = '{KIND_FWD, org, msg, self_id, !dlv};
        expect_result(res);
      end
      if (dlv) begin
        res = '{KIND_DLV, org, msg, 4'd0, 1'b1};
        expect_result(res);
      end
    end
  endfunction

  function automatic msg_key_t pick_key(int reuse_pct);
    msg_key_t key;
    if (known_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
      key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else begin
      key.origin = 4'($urandom_range(0, 15));
      key.msg    = $urandom();
    end
    return key;
  endfunction

  task automatic send_request(op_e op, logic [PID_W-1:0] org, logic [MSG_W-1:0] msg,
                              logic [PID_W-1:0] snd, bit use_model);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.op        <= op;
    req_bus.origin_id <= org;
    req_bus.msg_id    <= msg;
    req_bus.sender_id <= snd;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    track_request(op, org, msg, snd, use_model);
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    if (idx == REG_NUM_PROCS) group_size = value;
    else self_id = value[PID_W-1:0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(int n_items);
    int       done_items = 0;
    int       copies;
    msg_key_t key;
    while (done_items < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        key = pick_key(50);
        send_request(op_e'($urandom_range(0, 1)), key.origin, key.msg,
                     4'($urandom_range(0, 15)), 1'b1);
        done_items++;
      end else begin
        key = pick_key(30);
        send_request($urandom_range(0, 1) ? OP_LOCAL : OP_RECV, key.origin, key.msg,
                     4'($urandom_range(0, 15)), 1'b1);
        copies = $urandom_range(1, 12);
        repeat (copies) begin
          send_request(($urandom_range(0, 9) == 0) ? OP_LOCAL : OP_RECV, key.origin, key.msg,
                       4'($urandom_range(0, 15)), 1'b1);
        end
        done_items += copies + 1;
      end
    end
  endtask

  initial begin : rsp_sink
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_ask) begin
        rsp_hold_ask = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    bcast_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: kind %0d origin %0d msg %h",
               rsp_bus.kind, rsp_bus.out_origin, rsp_bus.out_msg);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, rsp_bus.kind);
          errors++;
        end
        if (rsp_bus.out_origin !== want.origin) begin
          $error("out_origin: expected %0d, actual %0d", want.origin, rsp_bus.out_origin);
          errors++;
        end
        if (rsp_bus.out_msg !== want.msg) begin
          $error("out_msg: expected %h, actual %h", want.msg, rsp_bus.out_msg);
          errors++;
        end
        if (rsp_bus.out_sender !== want.sender) begin
          $error("out_sender: expected %0d, actual %0d", want.sender, rsp_bus.out_sender);
          errors++;
        end
        if (rsp_bus.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    bcast_rsp_t fixed;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_NUM_PROCS;
    cfg_bus.data      = '0;
    req_bus.valid     = 1'b0;
    req_bus.op        = OP_LOCAL;
    req_bus.origin_id = '0;
    req_bus.msg_id    = '0;
    req_bus.sender_id = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg_write) begin
        write_register(dir_rows[r].reg_idx, dir_rows[r].reg_data);
      end else begin
        for (int j = 0; j < dir_rows[r].n_fixed; j++) begin
          fixed.kind   = (j == 0) ? dir_rows[r].k0 : dir_rows[r].k1;
          fixed.origin = dir_rows[r].origin;
          fixed.msg    = dir_rows[r].msg;
          fixed.sender = (fixed.kind == KIND_FWD) ? dir_rows[r].fwd_sender : 4'd0;
          fixed.last   = (j == dir_rows[r].n_fixed - 1);
          expect_result(fixed);
        end
        send_request(dir_rows[r].op, dir_rows[r].origin, dir_rows[r].msg,
                     dir_rows[r].sender, dir_rows[r].n_fixed < 0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_register(REG_NUM_PROCS, phase_np[p]);
      write_register(REG_LOCAL_ID, {1'b0, phase_lid[p]});
      quiet = (p == 2);
      if (p == 1) rsp_hold_ask = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    settle_block();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
